### rtl/sgsg_pkg.sv
// Shared types, constants and the stroke font table of the glyph segment generator.
package sgsg_pkg;

	localparam int SCALE_FRAC  = 12;
	localparam int COORD_W     = 18;
	localparam int COL_W       = 28;
	localparam int GLYPH_BYTES = 50;
	localparam int STR_W       = GLYPH_BYTES * 8;

	typedef enum logic [1:0] {
		REG_SCALE  = 2'd0,
		REG_VOFF   = 2'd1,
		REG_SWIDTH = 2'd2,
		REG_FWIDTH = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SKIP,
		ST_MAP,
		ST_EMIT,
		ST_ADV
	} seq_state_t;

	typedef struct packed {
		logic       map_en;
		logic [1:0] coord;
		logic [4:0] g;
		logic       emit;
		logic       last;
		logic       dot;
		logic       adv;
	} seq_ctrl_t;

	// Base-17 digit of the font strings: '0'..'9' then 'a'..'g'.
	function automatic logic [4:0] digit_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= "a") begin
			v = (c - "a") + 8'd10;
		end else begin
			v = c - "0";
		end
		return v[4:0];
	endfunction

	// Stroke string of a character code, last character in the lowest byte.
	function automatic logic [STR_W-1:0] font_str(input logic [7:0] code);
		logic [STR_W-1:0] s;
		s = '0;
		unique case (code)
			"a": s = "L2888L888eL8e2eL2e2bL2b8b";
			"b": s = "L121eL1888L888eL8e1e";
			"c": s = "L9818L181eL1e9e";
			"d": s = "L929eL9828L282eL2e9e";
			"e": s = "L1b9bL9b98L9818L181eL1e9e";
			"f": s = "L8252L525eL2787";
			"g": s = "L9828L282eL2e9eL989gL9g2g";
			"h": s = "L121eL1888L888e";
			"i": s = "D54L585e";
			"j": s = "D74L787gL7g2g";
			"k": s = "L121eL881cL4b9e";
			"l": s = "L424eL4e8e";
			"m": s = "L1e18L1848L484eL4888L888e";
			"n": s = "L1e18L1888L888e";
			"o": s = "L2888L888eL8e2eL2e28";
			"p": s = "L181gL1888L888eL8e1e";
			"q": s = "L989gL9828L282eL2e9e";
			"r": s = "L1e18L1888";
			"s": s = "L9818L181bL1b9bL9b9eL9e1e";
			"t": s = "L545eL2888L5e9e";
			"u": s = "L181eL1e8eL888e";
			"v": s = "L185eL5e98";
			"w": s = "L182eL2e5bL5b8eL8e98";
			"x": s = "L189eL981e";
			"y": s = "L185eL985eL5e3gL3g1g";
			"z": s = "L1898L981eL1e9e";
			"A": s = "L1e16L1652L5296L969eL1999";
			"B": s = "L121eL1272L7294L9497L9778L1878L789aL9a9cL9c7eL1e7e";
			"C": s = "L9212L121eL1e9e";
			"D": s = "L121eL1262L6295L959bL9b6eL1e6e";
			"E": s = "L9212L121eL1878L1e9e";
			"F": s = "L121eL1292L1878";
			"G": s = "L9212L121eL1e9eL9e98L9858";
			"H": s = "L121eL929eL1898";
			"I": s = "L3272L525eL3e7e";
			"J": s = "L929cL9c7eL7e3eL3e1c";
			"K": s = "L121eL9219L389e";
			"L": s = "L121eL1e9e";
			"M": s = "L1e12L1257L5792L929e";
			"N": s = "L1e12L129eL9e92";
			"O": s = "L1292L929eL9e1eL1e12";
			"P": s = "L121eL1282L8293L9397L9788L1888";
			"Q": s = "L1292L929eL9e1eL1e12L6b9e";
			"R": s = "L121eL1282L8293L9397L9788L1888L589e";
			"S": s = "L9212L1218L1898L989eL9e1e";
			"T": s = "L1292L525e";
			"U": s = "L121eL1e9eL9e92";
			"V": s = "L125eL5e92";
			"W": s = "L122eL2e59L598eL8e92";
			"X": s = "L129eL921e";
			"Y": s = "L1258L9258L585e";
			"Z": s = "L1292L921eL1e9e";
			"0": s = "L1292L929eL9e1eL1e12L832d";
			"1": s = "L2e8eL525eL2552";
			"2": s = "L1292L9297L971eL1e9e";
			"3": s = "L1292L9258L5898L989eL9e1e";
			"4": s = "L1a82L828eL1a9a";
			"5": s = "L9212L1218L1898L989eL9e1e";
			"6": s = "L9219L191eL1e9eL9e98L9818";
			"7": s = "L1292L923e";
			"8": s = "L1292L929eL9e1eL1e12L1898";
			"9": s = "L9818L1812L1292L929eL9e1e";
			".": s = "D5d";
			",": s = "L6c4f";
			":": s = "D54D5a";
			";": s = "D54L6a4f";
			"+": s = "L535bL1797";
			"-": s = "L1797";
			"/": s = "L901e";
			"\\": s = "L109e";
			"(": s = "L7034L343aL3a7e";
			")": s = "L3074L747aL7a3e";
			"[": s = "L8030L303eL3e8e";
			"]": s = "L2070L707eL7e2e";
			"<": s = "L8227L278c";
			">": s = "L2287L872c";
			"=": s = "L1595L1999";
			"%": s = "L2442L4253L5335L3524L901eL6b89L899aL9a7cL7c6b";
			"_": s = "L1e9e";
			"|": s = "L505e";
			"'": s = "L5044";
			"\"": s = "L3034L7074";
			"^": s = "L1853L5398";
			" ": s = '0;
			default: s = "L2282L828eL8e2eL2e22";
		endcase
		return s;
	endfunction

endpackage

### rtl/sgsg_map_unit.sv
// Shared scale, offset and round unit: maps one glyph coordinate to screen units.
module sgsg_map_unit #(
	parameter int COORD_FRAC_BITS = 4
) (
	input  logic signed [sgsg_pkg::COL_W-1:0]   origin_col,
	input  logic        [sgsg_pkg::COORD_W-1:0] origin_row,
	input  logic        [15:0]                  scale,
	input  logic        [4:0]                   g,
	input  logic                                is_row,
	output logic        [sgsg_pkg::COORD_W-1:0] coord
);
	localparam int SH    = sgsg_pkg::SCALE_FRAC - COORD_FRAC_BITS;
	localparam int SUM_W = sgsg_pkg::COL_W + 2;

	logic [20:0]             prod;
	logic signed [SUM_W-1:0] col_sum;
	logic [SUM_W-1:0]        row_off;

	always_comb begin
		prod    = g * scale;
		col_sum = SUM_W'(origin_col) + $signed(SUM_W'(prod))
			+ $signed(SUM_W'(1) <<< (SH - 1));
		row_off = SUM_W'(prod) + (SUM_W'(1) << (SH - 1));
		if (is_row) begin
			coord = origin_row + row_off[SH +: sgsg_pkg::COORD_W];
		end else begin
			coord = col_sum[SH +: sgsg_pkg::COORD_W];
		end
	end

endmodule

### rtl/sgsg_seq.sv
// Sequencer that walks the stroke string of one glyph and steps the map unit.
module sgsg_seq #(
	parameter int MAX_STROKES = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [7:0]            code,
	input  logic                  out_free,
	output sgsg_pkg::seq_ctrl_t   ctrl,
	output logic                  busy
);
	localparam int N_W = $clog2(MAX_STROKES);
	localparam int SW  = sgsg_pkg::STR_W;

	sgsg_pkg::seq_state_t state_q, state_d;
	logic [SW-1:0]  str_q, str_next;
	logic [1:0]     coord_q;
	logic [N_W-1:0] n_q;
	logic [7:0]     top, d1, d2, d3, d4;
	logic           dot, last;

	always_comb begin
		top      = str_q[SW-1 -: 8];
		d1       = str_q[SW-9 -: 8];
		d2       = str_q[SW-17 -: 8];
		d3       = str_q[SW-25 -: 8];
		d4       = str_q[SW-33 -: 8];
		dot      = (top == "D");
		str_next = dot ? (str_q << 24) : (str_q << 40);
		last     = (str_next[SW-1 -: 8] == 8'd0) || (n_q == N_W'(MAX_STROKES - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sgsg_pkg::ST_IDLE: begin
				if (start) state_d = sgsg_pkg::ST_SKIP;
			end
			sgsg_pkg::ST_SKIP: begin
				if (str_q == '0) state_d = sgsg_pkg::ST_ADV;
				else if (top != 8'd0) state_d = sgsg_pkg::ST_MAP;
			end
			sgsg_pkg::ST_MAP: begin
				if (coord_q == 2'd3) state_d = sgsg_pkg::ST_EMIT;
			end
			sgsg_pkg::ST_EMIT: begin
				if (out_free) state_d = last ? sgsg_pkg::ST_ADV : sgsg_pkg::ST_MAP;
			end
			sgsg_pkg::ST_ADV: state_d = sgsg_pkg::ST_IDLE;
			default: state_d = sgsg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.map_en = (state_q == sgsg_pkg::ST_MAP);
		ctrl.coord  = coord_q;
		unique case (coord_q)
			2'd0: ctrl.g = sgsg_pkg::digit_val(d1);
			2'd1: ctrl.g = sgsg_pkg::digit_val(d2);
			2'd2: ctrl.g = sgsg_pkg::digit_val(dot ? d1 : d3);
			default: ctrl.g = sgsg_pkg::digit_val(dot ? d2 : d4);
		endcase
		ctrl.emit = (state_q == sgsg_pkg::ST_EMIT) && out_free;
		ctrl.last = last;
		ctrl.dot  = dot;
		ctrl.adv  = (state_q == sgsg_pkg::ST_ADV);
		busy      = (state_q != sgsg_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgsg_pkg::ST_IDLE;
			coord_q <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sgsg_pkg::ST_IDLE) begin
				coord_q <= '0;
				n_q     <= '0;
			end
			if (state_q == sgsg_pkg::ST_MAP) coord_q <= coord_q + 2'd1;
			if (ctrl.emit) n_q <= n_q + N_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == sgsg_pkg::ST_IDLE) begin
			str_q <= sgsg_pkg::font_str(code);
		end else if (state_q == sgsg_pkg::ST_SKIP) begin
			if (str_q[SW-1 -: 40] == 40'd0) str_q <= str_q << 40;
			else if (top == 8'd0) str_q <= str_q << 8;
		end else if (ctrl.emit) begin
			str_q <= str_next;
		end
	end

endmodule

### rtl/stroke_glyph_segment_generator.sv
// Top level of the stroke glyph segment generator: registers, text origin and result beat.
//
//  channel | direction | tdata (low bit up)                              | tuser  | tlast
//  s_*     | in        | glyph[7:0] start_x[20:8] start_y[33:21]         | first  | -
//  m_*     | out       | seg_x0 seg_y0 seg_x1 seg_y1 (18 each) width_out | is_dot | last
//  cfg_*   | in        | cfg_idx selects scale, vertical_offset, stroke_width, frame_width
//
// A character beat is taken while the block is idle; its stroke string is then aligned
// (five bytes or one byte a cycle), each primitive makes four passes through the shared
// map unit plus one result load, and the advance comes last. A space only aligns and
// advances; a suppressed character never starts the sequencer. The input is not
// ready while a character is being worked on. A stalled result holds the sequencer
// in its emit step; the last result may wait in the output register while the next
// character is taken. Reset clears the origin, the suppress flag and the registers
// to their documented values.
module stroke_glyph_segment_generator #(
	parameter int MAX_STROKES     = 10,
	parameter int COORD_FRAC_BITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // glyph, start_x, start_y
	input  logic        s_tuser,   // first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // seg_x0, seg_y0, seg_x1, seg_y1, width_out
	output logic        m_tuser,   // is_dot
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);
	localparam int CW       = sgsg_pkg::COORD_W;
	localparam int COLW     = sgsg_pkg::COL_W;
	localparam int MIN_WID  = 1 << COORD_FRAC_BITS;

	logic [15:0] scale_q;
	logic [11:0] voff_q;
	logic [9:0]  swidth_q;
	logic [12:0] fwidth_q;

	logic signed [COLW-1:0] col_q, col_next;
	logic [CW-1:0]          row_q;
	logic                   supp_q;
	logic [CW-1:0]          pt_q [4];
	logic [CW-1:0]          map_out;
	logic [9:0]             width_eff;

	logic                   m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [87:0]            m_tdata_q;

	logic                   accept, start, busy, out_free;
	logic [7:0]             glyph;
	logic signed [12:0]     start_x, start_y;
	sgsg_pkg::seq_ctrl_t    ctrl;

	assign glyph    = s_tdata[7:0];
	assign start_x  = s_tdata[20:8];
	assign start_y  = s_tdata[33:21];
	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;
	// A first character reopens a string even after the frame edge was reached.
	assign start    = accept && (s_tuser || !supp_q);
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// Thin strokes are widened to one pixel.
	assign width_eff = (swidth_q < 10'(MIN_WID)) ? 10'(MIN_WID) : swidth_q;

	// The advance is twelve glyph units: 8 * scale + 4 * scale.
	assign col_next = col_q + COLW'({scale_q, 3'b000}) + COLW'({scale_q, 2'b00});

	sgsg_seq #(
		.MAX_STROKES(MAX_STROKES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.code     (glyph),
		.out_free (out_free),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	// Even passes map a column, odd passes a row.
	sgsg_map_unit #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_map (
		.origin_col (col_q),
		.origin_row (row_q),
		.scale      (scale_q),
		.g          (ctrl.g),
		.is_row     (ctrl.coord[0]),
		.coord      (map_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= 16'd4096;
			voff_q   <= '0;
			swidth_q <= 10'd16;
			fwidth_q <= 13'd640;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sgsg_pkg::REG_SCALE:  scale_q  <= cfg_data;
				sgsg_pkg::REG_VOFF:   voff_q   <= cfg_data[11:0];
				sgsg_pkg::REG_SWIDTH: swidth_q <= cfg_data[9:0];
				sgsg_pkg::REG_FWIDTH: fwidth_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Text origin: loaded by a first character, advanced after each character that is not suppressed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			supp_q <= 1'b0;
		end else if (accept && s_tuser) begin
			col_q  <= COLW'(start_x) <<< sgsg_pkg::SCALE_FRAC;
			row_q  <= (CW'(start_y) << COORD_FRAC_BITS) + CW'(voff_q);
			supp_q <= 1'b0;
		end else if (ctrl.adv) begin
			col_q  <= col_next;
			supp_q <= (col_next >= $signed(COLW'({fwidth_q, 12'd0})));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.map_en) pt_q[ctrl.coord] <= map_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			m_tdata_q <= {6'd0, width_eff, pt_q[3], pt_q[2], pt_q[1], pt_q[0]};
			m_tuser_q <= ctrl.dot;
			m_tlast_q <= ctrl.last;
		end
	end

`ifndef ASSERT_OFF
	a_beat_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(busy))
		else $error("result beat appeared with no character in work");

	a_suppressed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_tuser && supp_q) |=> !busy)
		else $error("suppressed character started the sequencer");

	a_min_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (m_tdata_q[81:72] >= 10'(MIN_WID)))
		else $error("stroke width below one pixel");
`endif

endmodule

### sim/stroke_glyph_segment_generator_test.sv
// Testbench of the stroke glyph segment generator: directed and random strings checked beat by beat.
`timescale 1ns / 1ps

module stroke_glyph_segment_generator_test;

	localparam int FRAC = 4;
	localparam int LIMIT_CYCLES = 400000;

	// One expected segment beat, in the block's field widths.
	typedef struct packed {
		logic [17:0] x0;
		logic [17:0] y0;
		logic [17:0] x1;
		logic [17:0] y1;
		logic        dot;
		logic [9:0]  width;
		logic        last;
	} segment_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // glyph, start_x, start_y
	logic        s_tuser;   // first
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // seg_x0, seg_y0, seg_x1, seg_y1, width_out
	logic        m_tuser;   // is_dot
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_data;

	stroke_glyph_segment_generator u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// Predictor's copy of the registers and the text origin.
	logic [15:0] scale_q;
	logic [11:0] voff_q;
	logic [9:0]  swidth_q;
	logic [12:0] fwidth_q;
	longint      pen_col;
	longint      pen_row;
	bit          string_muted;

	segment_t    pending_segments[$];
	int          fail_count;
	int          items_sent;
	int          segments_seen;
	int          cycle_count;
	bit          hold_off;      // long receiver stall requested by the pressure test
	bit          burst_mode;    // sender gaps enabled

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Base-17 digit as used in the font strings.
	function automatic int font_digit(input byte c);
		if (c >= "a")
			return c - "a" + 10;
		return c - "0";
	endfunction

	// Font string of a code; the same table as the block, written out independently.
	function automatic string glyph_strokes(input byte unsigned code);
		case (code)
			"a": return "L2888L888eL8e2eL2e2bL2b8b";
			"b": return "L121eL1888L888eL8e1e";
			"c": return "L9818L181eL1e9e";
			"d": return "L929eL9828L282eL2e9e";
			"e": return "L1b9bL9b98L9818L181eL1e9e";
			"f": return "L8252L525eL2787";
			"g": return "L9828L282eL2e9eL989gL9g2g";
			"h": return "L121eL1888L888e";
			"i": return "D54L585e";
			"j": return "D74L787gL7g2g";
			"k": return "L121eL881cL4b9e";
			"l": return "L424eL4e8e";
			"m": return "L1e18L1848L484eL4888L888e";
			"n": return "L1e18L1888L888e";
			"o": return "L2888L888eL8e2eL2e28";
			"p": return "L181gL1888L888eL8e1e";
			"q": return "L989gL9828L282eL2e9e";
			"r": return "L1e18L1888";
			"s": return "L9818L181bL1b9bL9b9eL9e1e";
			"t": return "L545eL2888L5e9e";
			"u": return "L181eL1e8eL888e";
			"v": return "L185eL5e98";
			"w": return "L182eL2e5bL5b8eL8e98";
			"x": return "L189eL981e";
			"y": return "L185eL985eL5e3gL3g1g";
			"z": return "L1898L981eL1e9e";
			"A": return "L1e16L1652L5296L969eL1999";
			"B": return "L121eL1272L7294L9497L9778L1878L789aL9a9cL9c7eL1e7e";
			"C": return "L9212L121eL1e9e";
			"D": return "L121eL1262L6295L959bL9b6eL1e6e";
			"E": return "L9212L121eL1878L1e9e";
			"F": return "L121eL1292L1878";
			"G": return "L9212L121eL1e9eL9e98L9858";
			"H": return "L121eL929eL1898";
			"I": return "L3272L525eL3e7e";
			"J": return "L929cL9c7eL7e3eL3e1c";
			"K": return "L121eL9219L389e";
			"L": return "L121eL1e9e";
			"M": return "L1e12L1257L5792L929e";
			"N": return "L1e12L129eL9e92";
			"O": return "L1292L929eL9e1eL1e12";
			"P": return "L121eL1282L8293L9397L9788L1888";
			"Q": return "L1292L929eL9e1eL1e12L6b9e";
			"R": return "L121eL1282L8293L9397L9788L1888L589e";
			"S": return "L9212L1218L1898L989eL9e1e";
			"T": return "L1292L525e";
			"U": return "L121eL1e9eL9e92";
			"V": return "L125eL5e92";
			"W": return "L122eL2e59L598eL8e92";
			"X": return "L129eL921e";
			"Y": return "L1258L9258L585e";
			"Z": return "L1292L921eL1e9e";
			"0": return "L1292L929eL9e1eL1e12L832d";
			"1": return "L2e8eL525eL2552";
			"2": return "L1292L9297L971eL1e9e";
			"3": return "L1292L9258L5898L989eL9e1e";
			"4": return "L1a82L828eL1a9a";
			"5": return "L9212L1218L1898L989eL9e1e";
			"6": return "L9219L191eL1e9eL9e98L9818";
			"7": return "L1292L923e";
			"8": return "L1292L929eL9e1eL1e12L1898";
			"9": return "L9818L1812L1292L929eL9e1e";
			".": return "D5d";
			",": return "L6c4f";
			":": return "D54D5a";
			";": return "D54L6a4f";
			"+": return "L535bL1797";
			"-": return "L1797";
			"/": return "L901e";
			"\\": return "L109e";
			"(": return "L7034L343aL3a7e";
			")": return "L3074L747aL7a3e";
			"[": return "L8030L303eL3e8e";
			"]": return "L2070L707eL7e2e";
			"<": return "L8227L278c";
			">": return "L2287L872c";
			"=": return "L1595L1999";
			"%": return "L2442L4253L5335L3524L901eL6b89L899aL9a7cL7c6b";
			"_": return "L1e9e";
			"|": return "L505e";
			"'": return "L5044";
			"\"": return "L3034L7074";
			"^": return "L1853L5398";
			" ": return "";
			default: return "L2282L828eL8e2eL2e22";
		endcase
	endfunction

	// Column in 1/16 pixel: the origin plus the scaled glyph unit, rounded half up.
	// An arithmetic shift of the biased sum floors, which gives round half up.
	function automatic logic [17:0] screen_col(input int g);
		longint v;
		v = pen_col + longint'(g) * longint'(scale_q)
			+ (longint'(1) << (sgsg_pkg::SCALE_FRAC - FRAC - 1));
		v = v >>> (sgsg_pkg::SCALE_FRAC - FRAC);
		return v[17:0];
	endfunction

	function automatic logic [17:0] screen_row(input int g);
		longint v;
		v = (longint'(g) * longint'(scale_q)
			+ (longint'(1) << (sgsg_pkg::SCALE_FRAC - FRAC - 1)))
			>> (sgsg_pkg::SCALE_FRAC - FRAC);
		v = pen_row + v;
		return v[17:0];
	endfunction

	// Works out the segments of one character beat and moves the origin.
	task automatic draw_glyph(input logic [7:0] code, input bit first,
			input logic [12:0] sx, input logic [12:0] sy);
		string    strokes;
		int       pos;
		int       n;
		segment_t seg;
		if (first) begin
			pen_col = longint'($signed(sx)) * 4096;
			pen_row = longint'($signed(sy)) * (1 << FRAC) + longint'(voff_q);
			string_muted = 0;
		end
		if (string_muted)
			return;
		strokes = glyph_strokes(code);
		pos = 0;
		n = 0;
		while (pos < strokes.len() && n < 10) begin
			seg.dot = (strokes[pos] == "D");
			seg.x0 = screen_col(font_digit(strokes[pos + 1]));
			seg.y0 = screen_row(font_digit(strokes[pos + 2]));
			seg.x1 = seg.dot ? seg.x0 : screen_col(font_digit(strokes[pos + 3]));
			seg.y1 = seg.dot ? seg.y0 : screen_row(font_digit(strokes[pos + 4]));
			seg.width = (swidth_q < (1 << FRAC)) ? 10'(1 << FRAC) : swidth_q;
			seg.last = 0;
			pending_segments.push_back(seg);
			pos += seg.dot ? 3 : 5;
			n++;
		end
		if (n > 0)
			pending_segments[pending_segments.size() - 1].last = 1;
		pen_col += 12 * longint'(scale_q);
		if (pen_col >= longint'(fwidth_q) * 4096)
			string_muted = 1;
	endtask

	// Sends one character beat, with a random gap before it when bursts are on.
	// The valid line stays up after a beat so that the next one can follow at once.
	task automatic send_glyph(input logic [7:0] code, input bit first,
			input logic [12:0] sx, input logic [12:0] sy);
		if (burst_mode && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, sy, sx, code};
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		draw_glyph(code, first, sx, sy);
		items_sent++;
	endtask

	// Waits for every expected segment, then lets the block settle before a register write.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pending_segments.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input sgsg_pkg::reg_idx_t idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			sgsg_pkg::REG_SCALE:  scale_q = value;
			sgsg_pkg::REG_VOFF:   voff_q = value[11:0];
			sgsg_pkg::REG_SWIDTH: swidth_q = value[9:0];
			sgsg_pkg::REG_FWIDTH: fwidth_q = value[12:0];
			default: ;
		endcase
	endtask

	// Random start within -2048..4095 pixels, inside the 13-bit signed field.
	function automatic logic [12:0] rand_start();
		int v;
		v = $urandom_range(0, 6143) - 2048;
		return v[12:0];
	endfunction

	// Printable code most of the time, with unknown and high codes mixed in.
	function automatic logic [7:0] rand_code();
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(128, 255));
			1: return 8'($urandom_range(0, 31));
			2: return " ";
			default: return 8'($urandom_range(32, 126));
		endcase
	endfunction

	// Random strings of 1 to 12 characters each, the first one loading the origin.
	task automatic send_strings(input int count);
		int i;
		int run;
		i = 0;
		while (i < count) begin
			run = $urandom_range(1, 12);
			send_glyph(rand_code(), 1'b1, rand_start(), rand_start());
			i++;
			repeat (run - 1) begin
				send_glyph(rand_code(), $urandom_range(0, 15) == 0, rand_start(), rand_start());
				i++;
			end
		end
	endtask

	// Extremes of the fields, every special case at reset register values.
	task automatic test_directed();
		send_glyph("B", 1'b1, 13'd0, 13'd0);          // ten segments, the most
		send_glyph("i", 1'b0, 13'd0, 13'd0);          // dot then line
		send_glyph(":", 1'b0, 13'd0, 13'd0);          // two dots
		send_glyph(" ", 1'b0, 13'd0, 13'd0);          // space only advances
		send_glyph(8'hFF, 1'b0, 13'd0, 13'd0);        // high code gives the box
		send_glyph(8'h00, 1'b0, 13'd0, 13'd0);        // unknown low code
		send_glyph("%", 1'b1, 13'h1000, 13'h1000);    // most negative start
		send_glyph("g", 1'b0, 13'h1000, 13'h1000);
		send_glyph("W", 1'b1, 13'd4095, 13'd4095);    // starts past the frame, still drawn
		send_glyph("W", 1'b0, 13'd0, 13'd0);          // suppressed
		send_glyph("M", 1'b0, 13'h1FFF, 13'h1FFF);    // still suppressed
		send_glyph("0", 1'b1, 13'd620, 13'h0AAA);     // starts near the right edge
		send_glyph("1", 1'b0, 13'h1555, 13'h0555);    // drawn; its advance passes the frame width
		send_glyph("~", 1'b1, 13'h1FFF, 13'd5);       // unknown printable code
		drain_block();
	endtask

	// Register extremes, one setting per phase, each followed by strings.
	task automatic test_registers();
		write_reg(sgsg_pkg::REG_SCALE, 16'hFFFF);
		write_reg(sgsg_pkg::REG_VOFF, 16'd4095);
		write_reg(sgsg_pkg::REG_SWIDTH, 16'd1023);
		write_reg(sgsg_pkg::REG_FWIDTH, 16'd4096);
		send_strings(20);
		drain_block();
		write_reg(sgsg_pkg::REG_SCALE, 16'd1);
		write_reg(sgsg_pkg::REG_VOFF, 16'd0);
		write_reg(sgsg_pkg::REG_SWIDTH, 16'd0);        // thin strokes widened to a pixel
		write_reg(sgsg_pkg::REG_FWIDTH, 16'd1);
		send_strings(20);
		drain_block();
		write_reg(sgsg_pkg::REG_SCALE, 16'd0);         // every point on the origin
		write_reg(sgsg_pkg::REG_FWIDTH, 16'd0);        // suppresses after the first glyph if the start is not negative
		write_reg(sgsg_pkg::REG_SWIDTH, 16'd15);
		send_strings(15);
		drain_block();
		write_reg(sgsg_pkg::REG_SCALE, 16'd3277);
		write_reg(sgsg_pkg::REG_VOFF, 16'd137);
		write_reg(sgsg_pkg::REG_SWIDTH, 16'd24);
		write_reg(sgsg_pkg::REG_FWIDTH, 16'd8191);     // top of the 13-bit field
		send_strings(15);
		drain_block();
	endtask

	// Bulk random traffic over four random register settings.
	task automatic test_random();
		repeat (4) begin
			write_reg(sgsg_pkg::REG_SCALE, 16'($urandom_range(1, 16'hFFFF)));
			write_reg(sgsg_pkg::REG_VOFF, 16'($urandom_range(0, 4095)));
			write_reg(sgsg_pkg::REG_SWIDTH, 16'($urandom_range(0, 1023)));
			write_reg(sgsg_pkg::REG_FWIDTH, 16'($urandom_range(1, 4096)));
			send_strings(70);
			drain_block();
		end
	endtask

	// The receiver stops for a long time while characters keep coming.
	task automatic test_backpressure();
		write_reg(sgsg_pkg::REG_SCALE, 16'd4096);
		write_reg(sgsg_pkg::REG_FWIDTH, 16'd4096);
		hold_off = 1;
		send_strings(30);
		drain_block();
	endtask

	// Receiver stall pattern: long stretches ready, stretches of random stalls.
	initial begin
		int phase;
		m_tready = 1'b0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			phase = (phase + 1) % 300;
			if (phase < 100)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	// Checks each accepted segment beat against the oldest expectation.
	always @(posedge clk) begin
		segment_t want;
		if (arst_n && m_tvalid && m_tready) begin
			segments_seen++;
			if (pending_segments.size() == 0) begin
				$error("segment beat with no character pending: %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_segments.pop_front();
				if (m_tdata[17:0] !== want.x0) begin
					$error("seg_x0 expected %h got %h", want.x0, m_tdata[17:0]);
					fail_count++;
				end
				if (m_tdata[35:18] !== want.y0) begin
					$error("seg_y0 expected %h got %h", want.y0, m_tdata[35:18]);
					fail_count++;
				end
				if (m_tdata[53:36] !== want.x1) begin
					$error("seg_x1 expected %h got %h", want.x1, m_tdata[53:36]);
					fail_count++;
				end
				if (m_tdata[71:54] !== want.y1) begin
					$error("seg_y1 expected %h got %h", want.y1, m_tdata[71:54]);
					fail_count++;
				end
				if (m_tdata[81:72] !== want.width) begin
					$error("width_out expected %0d got %0d", want.width, m_tdata[81:72]);
					fail_count++;
				end
				if (m_tuser !== want.dot) begin
					$error("is_dot expected %b got %b", want.dot, m_tuser);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last expected %b got %b", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("stroke_glyph_segment_generator_test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = sgsg_pkg::REG_SCALE;
		cfg_data = '0;
		scale_q = 16'd4096;
		voff_q = '0;
		swidth_q = 10'd16;
		fwidth_q = 13'd640;
		pen_col = 0;
		pen_row = 0;
		string_muted = 0;
		fail_count = 0;
		items_sent = 0;
		segments_seen = 0;
		cycle_count = 0;
		hold_off = 0;
		burst_mode = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		burst_mode = 1;
		test_registers();
		test_random();
		test_backpressure();
		if (pending_segments.size() != 0) begin
			$error("%0d segments never arrived", pending_segments.size());
			fail_count++;
		end
		$display("Sent %0d characters over several register settings and checked %0d segments,",
			items_sent, segments_seen);
		$display("including spaces, box glyphs, dots, edge suppression and a long output stall.");
		if (fail_count == 0) begin
			$display("stroke_glyph_segment_generator_test passed");
		end else begin
			$display("stroke_glyph_segment_generator_test failed");
		end
		$finish;
	end

endmodule
